FILE: hw/rtl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

	// Item action codes
	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_ERROR  = 2'd1;
	localparam logic [1:0] ACT_RESET  = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_POWER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIBERNATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd5;

	localparam int unsigned MV_W     = 14;
	localparam int unsigned MARGIN_W = 10;
	localparam int unsigned MODE_W   = 3;

	// Reset values of the thresholds, in millivolts
	localparam logic [MV_W-1:0]     FULL_MV_RST      = 14'd8200;
	localparam logic [MV_W-1:0]     NORMAL_MV_RST    = 14'd7300;
	localparam logic [MV_W-1:0]     LOW_POWER_MV_RST = 14'd6900;
	localparam logic [MV_W-1:0]     HIBERNATE_MV_RST = 14'd6200;
	localparam logic [MV_W-1:0]     DEAD_MV_RST      = 14'd6000;
	localparam logic [MARGIN_W-1:0] MARGIN_MV_RST    = 10'd300;

	typedef struct packed {
		logic [MV_W-1:0]     full_mv;
		logic [MV_W-1:0]     normal_mv;
		logic [MV_W-1:0]     low_power_mv;
		logic [MV_W-1:0]     hibernate_mv;
		logic [MV_W-1:0]     dead_mv;
		logic [MARGIN_W-1:0] charge_margin_mv;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [MODE_W-1:0] previous_mode;
		logic              entered;
		logic              is_charging;
		logic              is_full;
		logic              error_flag;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bpm_item_if.sv
`default_nettype none

interface bpm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [13:0] battery_mv;
	logic [13:0] solar_mv;

	modport source (output valid, action, battery_mv, solar_mv, input ready);
	modport sink (input valid, action, battery_mv, solar_mv, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bpm_report_if.sv
`default_nettype none

interface bpm_report_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [2:0] previous_mode;
	logic       entered;
	logic       is_charging;
	logic       is_full;
	logic       error_flag;

	modport source (output valid, mode, previous_mode, entered, is_charging, is_full,
		error_flag, input ready);
	modport sink (input valid, mode, previous_mode, entered, is_charging, is_full,
		error_flag, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bpm_cfg_regs.sv
`default_nettype none

module bpm_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bpm_pkg::MV_W-1:0]      cfg_data,
	output bpm_pkg::cfg_t                      cfg
);
	import bpm_pkg::*;

	cfg_t cfg_q;

	// Write the addressed threshold; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_mv          <= FULL_MV_RST;
			cfg_q.normal_mv        <= NORMAL_MV_RST;
			cfg_q.low_power_mv     <= LOW_POWER_MV_RST;
			cfg_q.hibernate_mv     <= HIBERNATE_MV_RST;
			cfg_q.dead_mv          <= DEAD_MV_RST;
			cfg_q.charge_margin_mv <= MARGIN_MV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FULL:      cfg_q.full_mv          <= cfg_data;
				REG_NORMAL:    cfg_q.normal_mv        <= cfg_data;
				REG_LOW_POWER: cfg_q.low_power_mv     <= cfg_data;
				REG_HIBERNATE: cfg_q.hibernate_mv     <= cfg_data;
				REG_DEAD:      cfg_q.dead_mv          <= cfg_data;
				REG_MARGIN:    cfg_q.charge_margin_mv <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bpm_core.sv
`default_nettype none

module bpm_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bpm_pkg::cfg_t            cfg,
	input  wire logic                     step,
	input  wire logic [1:0]               action,
	input  wire logic [bpm_pkg::MV_W-1:0] battery_mv,
	input  wire logic [bpm_pkg::MV_W-1:0] solar_mv,
	output bpm_pkg::res_t                 res
);
	import bpm_pkg::*;

	typedef enum logic [MODE_W-1:0] {
		ST_BOOT      = 3'd0,
		ST_CHECK     = 3'd1,
		ST_CHARGING  = 3'd2,
		ST_NORMAL    = 3'd3,
		ST_LOW       = 3'd4,
		ST_CRITICAL  = 3'd5,
		ST_HIBERNATE = 3'd6,
		ST_ERROR     = 3'd7
	} mode_t;

	mode_t             mode_q, mode_d, trans;
	logic [MODE_W-1:0] prior_q, prior_d;
	logic              err_q, err_d, rst_q, rst_d, chg_q, chg_d, full_q, full_d;
	logic              is_upd, chg_new, full_new, entered;
	logic [MV_W:0]     bat_plus_margin;

	// Work out the measurement flags
	assign is_upd          = (action == ACT_UPDATE);
	assign bat_plus_margin = {1'b0, battery_mv} + {{(MV_W + 1 - MARGIN_W){1'b0}},
		cfg.charge_margin_mv};
	assign chg_new         = {1'b0, solar_mv} > bat_plus_margin;
	assign full_new        = battery_mv >= cfg.full_mv;

	// Transition rule of the current mode on an update
	always_comb begin
		trans = mode_q;
		case (mode_q)
			ST_BOOT: trans = ST_CHECK;
			ST_CHECK: begin
				if (err_q)                               trans = ST_ERROR;
				else if (battery_mv <= cfg.dead_mv)      trans = ST_HIBERNATE;
				else if (chg_new && !full_new)           trans = ST_CHARGING;
				else if (battery_mv >= cfg.normal_mv)    trans = ST_NORMAL;
				else if (battery_mv >= cfg.low_power_mv) trans = ST_LOW;
				else                                     trans = ST_CRITICAL;
			end
			ST_CHARGING: begin
				if (err_q)         trans = ST_ERROR;
				else if (full_new) trans = ST_CHECK;
			end
			ST_NORMAL: begin
				if (err_q)                          trans = ST_ERROR;
				else if (battery_mv < cfg.normal_mv) trans = ST_LOW;
			end
			ST_LOW: begin
				if (err_q)                               trans = ST_ERROR;
				else if (battery_mv >= cfg.normal_mv)    trans = ST_NORMAL;
				else if (chg_new)                        trans = ST_CHECK;
				else if (battery_mv < cfg.low_power_mv)  trans = ST_CRITICAL;
			end
			ST_CRITICAL: begin
				if (err_q)                               trans = ST_ERROR;
				else if (battery_mv <= cfg.hibernate_mv) trans = ST_HIBERNATE;
				else if (battery_mv >= cfg.low_power_mv) trans = ST_CHECK;
			end
			ST_HIBERNATE: begin
				if (battery_mv > cfg.dead_mv) trans = ST_BOOT;
			end
			ST_ERROR: begin
				if (rst_q) trans = ST_BOOT;
			end
			default: trans = mode_q;
		endcase
	end

	// Next state of all latches for the item at hand
	always_comb begin
		mode_d  = mode_q;
		prior_d = prior_q;
		err_d   = err_q;
		rst_d   = rst_q;
		chg_d   = chg_q;
		full_d  = full_q;
		entered = 1'b0;
		case (action)
			ACT_UPDATE: begin
				chg_d  = chg_new;
				full_d = full_new;
				if (mode_q == ST_ERROR) begin
					err_d = 1'b0;
					rst_d = 1'b0;
				end
				if (trans != mode_q) begin
					prior_d = mode_q;
					mode_d  = trans;
					entered = 1'b1;
				end
			end
			ACT_ERROR: err_d = 1'b1;
			ACT_RESET: rst_d = 1'b1;
			default: ;
		endcase
	end

	// Hold the controller state; advance it when an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ST_BOOT;
			prior_q <= ST_BOOT;
			err_q   <= 1'b0;
			rst_q   <= 1'b0;
			chg_q   <= 1'b0;
			full_q  <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			prior_q <= prior_d;
			err_q   <= err_d;
			rst_q   <= rst_d;
			chg_q   <= chg_d;
			full_q  <= full_d;
		end
	end

	// Report for this item (ignored when is_upd is low apart from held values)
	assign res.mode          = mode_d;
	assign res.previous_mode = prior_d;
	assign res.entered       = entered && is_upd;
	assign res.is_charging   = chg_d;
	assign res.is_full       = full_d;
	assign res.error_flag    = err_d;

endmodule

`default_nettype wire

FILE: hw/rtl/battery_power_mode_fsm.sv
// Battery power-mode controller.
// Items arrive on the meas channel: action 0 is a measurement update carrying
// battery_mv and solar_mv, action 1 raises a pending error, action 2 requests
// a reset; code 3 is ignored. Each item gives exactly one transaction on the
// report channel with the mode, the mode before the last transition, an entry
// pulse and the charging, full and error flags.
// Thresholds are written over cfg_we / cfg_index / cfg_data; the user must write
// them only while idle, as the block itself does not enforce it. An item
// passes the input register, then the combinational mode update, then the
// report register. Throughput is one item per clock while the receiver does
// not stall, set by the combinational mode update between the two registers.
// When the receiver stalls, the held report waits and one more item is still
// taken into the input register; meas.ready then drops until the report moves.
// Reset clears both valid bits, puts the controller in boot with all flags
// low and loads the default thresholds; no items are in flight afterwards.
`default_nettype none

module battery_power_mode_fsm (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bpm_pkg::MV_W-1:0]      cfg_data,
	bpm_item_if.sink                           meas,
	bpm_report_if.source                       report
);
	import bpm_pkg::*;

	cfg_t             cfg;
	res_t             res_nxt, res_q;
	logic             res_valid_q;
	logic             valid_s1, advance;
	logic [1:0]       action_s1;
	logic [MV_W-1:0]  battery_s1, solar_s1;

	bpm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move the staged item on when the report register is empty or being emptied
	assign advance    = valid_s1 && (!res_valid_q || report.ready);
	assign meas.ready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (meas.ready) begin
			valid_s1 <= meas.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (meas.ready && meas.valid) begin
			action_s1  <= meas.action;
			battery_s1 <= meas.battery_mv;
			solar_s1   <= meas.solar_mv;
		end
	end

	bpm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (advance),
		.action     (action_s1),
		.battery_mv (battery_s1),
		.solar_mv   (solar_s1),
		.res        (res_nxt)
	);

	// Report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (report.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign report.valid         = res_valid_q;
	assign report.mode          = res_q.mode;
	assign report.previous_mode = res_q.previous_mode;
	assign report.entered       = res_q.entered;
	assign report.is_charging   = res_q.is_charging;
	assign report.is_full       = res_q.is_full;
	assign report.error_flag    = res_q.error_flag;

endmodule

`default_nettype wire
